### rtl/core/pswd_pkg.sv
// ----------------------------------------------------------------------------
// pswd_pkg
// shared types and constants of the per-channel stall watchdog
// ----------------------------------------------------------------------------
package pswd_pkg;

    localparam int CH_W    = 7;
    localparam int DIST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int OP_W    = 2;
    localparam int CH_SPAN = 1 << CH_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLR_ONE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR_ALL = 2'd2;

    // register indexes
    localparam logic CFG_IDX_INTERVAL  = 1'b0;
    localparam logic CFG_IDX_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd5;

    // one table entry
    typedef struct packed {
        logic              detecting;
        logic              collision_seen;
        logic [DIST_W-1:0] ref_distance;
        logic [TIME_W-1:0] ref_time;
    } t_entry;

    // table update controls
    typedef struct packed {
        logic wr_en;
        logic clr_one;
        logic clr_all;
    } t_ctrl;

    // decision for one item
    typedef struct packed {
        t_ctrl  ctrl;
        t_entry entry;
        logic   stuck;
    } t_action;

endpackage

### rtl/core/progress_stall_watchdog_table_top.sv
// ----------------------------------------------------------------------------
// progress_stall_watchdog_table_top
// per-channel stall watchdog with a channel table in synchronous memory
// ----------------------------------------------------------------------------
// Each input word carries one operation on one channel: a check, a clear of
// one channel or a clear of all channels. Every word yields exactly one output
// word whose bit 0 is the stuck flag. A check arms an idle channel with the
// current distance and time; once the elapsed time (modulo 2^32, read as
// signed) exceeds interval_ms, a channel that saw a collision and moved less
// than move_threshold is reported stuck and goes idle, otherwise it rearms.
// In the idle state an accepted item reads its channel entry from the
// single-port table memory into a register; in the look state the entry is
// evaluated, written back and the output register is loaded. The next word
// is taken right after, provided the previous result has been taken or is
// taken in that cycle, so no new word is taken while one is being evaluated.
// Channel flags are kept valid by per-entry flops, so there is no clearing
// pass after reset and clear-all resets every flag at once. Configuration
// writes are always accepted and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module progress_stall_watchdog_table_top
    import pswd_pkg::*;
#(
    parameter int NUM_CHANNELS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] channel, [7] collidable, [8] collided, [24:9] distance,
    // [56:25] time_now, [63:57] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] stuck, [7:1] zero
    output logic [7:0]  m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // only the first CH_SPAN channels can be addressed by the channel field
    localparam int DEPTH = (NUM_CHANNELS < CH_SPAN) ? NUM_CHANNELS : CH_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state            r_state, n_state;

    // held item
    logic [OP_W-1:0]   r_op;
    logic [CH_W-1:0]   r_channel;
    logic              r_collidable;
    logic              r_collided;
    logic [DIST_W-1:0] r_distance;
    logic [TIME_W-1:0] r_time_now;

    // configuration
    logic [CFG_W-1:0]  r_interval;
    logic [CFG_W-1:0]  r_threshold;

    // output register
    logic              r_out_valid;
    logic              r_stuck;

    logic              in_accept;
    logic              in_range;
    t_entry            rd_entry;
    t_action           action;
    t_ctrl             tbl_ctrl;

    // input side is free while idle and once the output register can take the next result
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_stuck};

    assign in_range = ({{(32-CH_W){1'b0}}, r_channel} < 32'(NUM_CHANNELS));

    // table updates only happen in the evaluation cycle
    always_comb begin
        tbl_ctrl = '0;
        if (r_state == S_LOOK) begin
            tbl_ctrl = action.ctrl;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = S_LOOK;
            S_LOOK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_interval  <= INTERVAL_RST;
            r_threshold <= THRESHOLD_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOOK) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IDX_INTERVAL:  r_interval  <= i_cfg_data;
                    CFG_IDX_THRESHOLD: r_threshold <= i_cfg_data;
                    default:           r_interval  <= r_interval;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op         <= s_axis_tuser;
            r_channel    <= s_axis_tdata[6:0];
            r_collidable <= s_axis_tdata[7];
            r_collided   <= s_axis_tdata[8];
            r_distance   <= s_axis_tdata[24:9];
            r_time_now   <= s_axis_tdata[56:25];
        end
        if (r_state == S_LOOK) begin
            r_stuck <= action.stuck;
        end
    end

    pswd_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr  (s_axis_tdata[AW-1:0]),
        .o_rd_entry (rd_entry),
        .i_ctrl     (tbl_ctrl),
        .i_wr_addr  (r_channel[AW-1:0]),
        .i_wr_entry (action.entry)
    );

    pswd_eval u_eval (
        .i_op         (r_op),
        .i_in_range   (in_range),
        .i_collidable (r_collidable),
        .i_collided   (r_collided),
        .i_distance   (r_distance),
        .i_time_now   (r_time_now),
        .i_entry      (rd_entry),
        .i_interval   (r_interval),
        .i_threshold  (r_threshold),
        .o_action     (action)
    );

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOK))
        else $error("accepted word not evaluated next cycle");

    a_look_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_out_valid && r_state == S_IDLE))
        else $error("evaluation did not produce a result");

    a_stuck_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOK) && action.stuck) |-> (tbl_ctrl.clr_one && !tbl_ctrl.wr_en))
        else $error("stuck channel not returned to idle");

endmodule

### rtl/core/pswd_table.sv
// ----------------------------------------------------------------------------
// pswd_table
// channel table: synchronous memory plus per-entry valid flops
// ----------------------------------------------------------------------------
module pswd_table
    import pswd_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_entry,
    input  t_ctrl         i_ctrl,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_entry
);

    t_entry           r_mem [DEPTH];
    t_entry           r_rd_data;
    logic             r_rd_valid;
    logic [DEPTH-1:0] r_valid;

    // memory port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid flops stand for the all-zero flag reset of each entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctrl.clr_one) begin
                r_valid[i_wr_addr] <= 1'b0;
            end else if (i_ctrl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_entry                = r_rd_data;
        o_rd_entry.detecting      = r_rd_data.detecting & r_rd_valid;
        o_rd_entry.collision_seen = r_rd_data.collision_seen & r_rd_valid;
    end

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.wr_en && (i_ctrl.clr_one || i_ctrl.clr_all)))
        else $error("table write and clear in the same cycle");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_en |=> r_valid[$past(i_wr_addr)])
        else $error("written entry not marked valid");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clr_all |=> (r_valid == '0))
        else $error("clear-all left a valid entry");

endmodule

### rtl/core/pswd_eval.sv
// ----------------------------------------------------------------------------
// pswd_eval
// decision logic: from an item and its table entry to the update and result
// ----------------------------------------------------------------------------
module pswd_eval
    import pswd_pkg::*;
(
    input  logic [OP_W-1:0]   i_op,
    input  logic              i_in_range,
    input  logic              i_collidable,
    input  logic              i_collided,
    input  logic [DIST_W-1:0] i_distance,
    input  logic [TIME_W-1:0] i_time_now,
    input  t_entry            i_entry,
    input  logic [CFG_W-1:0]  i_interval,
    input  logic [CFG_W-1:0]  i_threshold,
    output t_action           o_action
);

    logic [TIME_W-1:0] elapsed;
    logic [DIST_W-1:0] moved;
    logic              seen;
    logic              window_open;
    t_entry            armed;

    always_comb begin
        elapsed     = i_time_now - i_entry.ref_time;
        // negative elapsed time never ends the window
        window_open = elapsed[TIME_W-1] ||
                      (elapsed <= {{(TIME_W-CFG_W){1'b0}}, i_interval});
        moved       = (i_entry.ref_distance >= i_distance)
                      ? (i_entry.ref_distance - i_distance)
                      : (i_distance - i_entry.ref_distance);
        seen        = i_entry.collision_seen | i_collided;

        armed.detecting      = 1'b1;
        armed.collision_seen = 1'b0;
        armed.ref_distance   = i_distance;
        armed.ref_time       = i_time_now;

        o_action       = '0;
        o_action.entry = armed;

        case (i_op)
            OP_CHECK: begin
                if (i_in_range) begin
                    if (!i_collidable) begin
                        o_action.ctrl.clr_one = 1'b1;
                    end else if (!i_entry.detecting) begin
                        o_action.ctrl.wr_en = 1'b1;
                    end else if (window_open) begin
                        // keep references, record the collision
                        o_action.ctrl.wr_en                = 1'b1;
                        o_action.entry                     = i_entry;
                        o_action.entry.collision_seen      = seen;
                    end else if (!seen) begin
                        o_action.ctrl.wr_en = 1'b1;
                    end else if (moved < i_threshold) begin
                        o_action.ctrl.clr_one = 1'b1;
                        o_action.stuck        = 1'b1;
                    end else begin
                        o_action.ctrl.wr_en = 1'b1;
                    end
                end
            end
            OP_CLR_ONE: begin
                o_action.ctrl.clr_one = i_in_range;
            end
            OP_CLR_ALL: begin
                o_action.ctrl.clr_all = 1'b1;
            end
            default: begin
                o_action.ctrl = '0;
            end
        endcase
    end

endmodule

### sim/pswd_checker.sv
// ----------------------------------------------------------------------------
// pswd_checker
// watches the channels of the stall watchdog, predicts and compares results
// ----------------------------------------------------------------------------
// Keeps its own copy of the channel table and of both registers. Every word
// taken on the input stream is run through the predictor, and the stuck
// verdict joins a queue. Every word taken on the result stream is compared
// with the oldest verdict in that queue.
// ----------------------------------------------------------------------------
module pswd_checker
    import pswd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_words,
    output int          o_stuck,
    output int          o_cfg_writes
);

    localparam int PRINT_CAP = 40;

    t_entry            chan_tab [CH_SPAN];
    logic [CFG_W-1:0]  interval_cfg;
    logic [CFG_W-1:0]  threshold_cfg;
    logic              stuck_due_q [$];
    logic              due_stuck;
    logic              verdict;
    int                err_count;
    int                word_count;
    int                result_count;
    int                stuck_count;
    int                write_count;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        err_count++;
        // later mismatches are only counted
        if (err_count <= PRINT_CAP)
            $display("%0t: %s mismatch on result %0d: expected %0h, got %0h",
                     $time, what, result_count, want, got);
    endtask

    // runs one word through the channel table, returns the stuck verdict
    function automatic logic watchdog_verdict(input logic [OP_W-1:0] op,
                                              input logic [CH_W-1:0] ch,
                                              input logic able,
                                              input logic hit,
                                              input logic [DIST_W-1:0] cur_dist,
                                              input logic [TIME_W-1:0] now);
        t_entry             e;
        logic [TIME_W-1:0]  elapsed;
        logic [DIST_W-1:0]  moved;
        logic               stuck;
        int                 i;
        stuck = 1'b0;
        case (op)
            OP_CHECK: begin
                e = chan_tab[ch];
                if (!able) begin
                    e.detecting      = 1'b0;
                    e.collision_seen = 1'b0;
                end else if (!e.detecting) begin
                    e = '{detecting: 1'b1, collision_seen: 1'b0,
                          ref_distance: cur_dist, ref_time: now};
                end else begin
                    if (hit)
                        e.collision_seen = 1'b1;
                    elapsed = now - e.ref_time;
                    // negative elapsed time never closes the window
                    if (!elapsed[TIME_W-1] && elapsed > {16'd0, interval_cfg}) begin
                        moved = (e.ref_distance >= cur_dist) ? e.ref_distance - cur_dist
                                                             : cur_dist - e.ref_distance;
                        if (e.collision_seen && moved < threshold_cfg) begin
                            e.detecting      = 1'b0;
                            e.collision_seen = 1'b0;
                            stuck            = 1'b1;
                        end else begin
                            e = '{detecting: 1'b1, collision_seen: 1'b0,
                                  ref_distance: cur_dist, ref_time: now};
                        end
                    end
                end
                chan_tab[ch] = e;
            end
            OP_CLR_ONE: begin
                chan_tab[ch].detecting      = 1'b0;
                chan_tab[ch].collision_seen = 1'b0;
            end
            OP_CLR_ALL: begin
                for (i = 0; i < CH_SPAN; i++) begin
                    chan_tab[i].detecting      = 1'b0;
                    chan_tab[i].collision_seen = 1'b0;
                end
            end
            default: ;
        endcase
        return stuck;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CH_SPAN; i++)
                chan_tab[i] = '0;
            interval_cfg  = INTERVAL_RST;
            threshold_cfg = THRESHOLD_RST;
            stuck_due_q.delete();
            err_count     = 0;
            word_count    = 0;
            result_count  = 0;
            stuck_count   = 0;
            write_count   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_INTERVAL)
                    interval_cfg = i_cfg_data;
                else
                    threshold_cfg = i_cfg_data;
                write_count++;
            end
            // results first: a result never belongs to a word taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (stuck_due_q.size() == 0) begin
                    report_mismatch("unexpected result", 8'h00, m_axis_tdata);
                end else begin
                    due_stuck = stuck_due_q.pop_front();
                    if (m_axis_tdata[0] !== due_stuck)
                        report_mismatch("stuck", {7'd0, due_stuck}, m_axis_tdata);
                    if (m_axis_tdata[7:1] !== 7'd0)
                        report_mismatch("padding", {7'd0, due_stuck}, m_axis_tdata);
                end
                result_count++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                verdict = watchdog_verdict(s_axis_tuser, s_axis_tdata[6:0],
                                           s_axis_tdata[7], s_axis_tdata[8],
                                           s_axis_tdata[24:9], s_axis_tdata[56:25]);
                stuck_due_q.push_back(verdict);
                word_count++;
                if (verdict)
                    stuck_count++;
            end
        end
        o_errors     <= err_count;
        o_pending    <= stuck_due_q.size();
        o_words      <= word_count;
        o_stuck      <= stuck_count;
        o_cfg_writes <= write_count;
    end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the per-channel stall watchdog
// ----------------------------------------------------------------------------
// A directed opening walks the window boundary, timer wrap, negative elapsed
// time, the move threshold edge, clears and the unused operation. Then eight
// register settings follow, the extremes among them, each with a burst of
// random words that revisit a small pool of channels with a timer that moves
// forward, so windows close often. Both sides stall at random, the result
// side holds off once for a long stretch, and the last setting runs with no
// stalls at all. The checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import pswd_pkg::*;

    localparam int              CYCLE_LIMIT     = 200000;
    localparam int              NUM_PHASES      = 8;
    localparam int              WORDS_PER_PHASE = 140;
    localparam int              HOLD_CYCLES     = 60;
    localparam int              POOL_SIZE       = 4;
    localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    int          fail_count;
    int          verdicts_pending;
    int          words_seen;
    int          stuck_seen;
    int          writes_seen;
    int          cycles;

    // stall control shared by the two sides
    bit          send_gaps;
    bit          recv_gaps;
    bit          hold_req;
    bit          hold_done;

    // random stimulus state
    logic [TIME_W-1:0] clock_ms;
    logic [CH_W-1:0]   chan_pool [POOL_SIZE];
    logic [DIST_W-1:0] last_dist [CH_SPAN];

    progress_stall_watchdog_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pswd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_count),
        .o_pending     (verdicts_pending),
        .o_words       (words_seen),
        .o_stuck       (stuck_seen),
        .o_cfg_writes  (writes_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles,
                 verdicts_pending);
        $display("[progress_stall_watchdog_table_top] ERROR");
        $finish;
    end

    // result side: short random stalls, one long hold-off on request
    initial begin : result_sink
        int n;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                // sender keeps offering words meanwhile, so the block backs up
                m_axis_tready = 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++)
                    @(negedge i_clk);
                hold_done = 1'b1;
            end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // one word on the input stream, optionally after a short idle burst
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic able, input logic hit,
                             input logic [DIST_W-1:0] cur_dist,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, now, cur_dist, hit, able, ch};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop offering words and wait until every verdict has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (verdicts_pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly checks on a small channel pool with a forward-moving timer
    task automatic send_random_word(input int intv, input int thr);
        int              r;
        int              d;
        logic [CH_W-1:0] ch;
        logic            hit;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = clock_ms - $urandom_range(0, intv);
        else if (r == 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, intv / 2 + 2);

        if ($urandom_range(0, 9) == 0)
            ch = CH_W'($urandom_range(0, CH_SPAN - 1));
        else
            ch = chan_pool[$urandom_range(0, POOL_SIZE - 1)];

        // distance wanders around the threshold, sometimes jumps anywhere
        if ($urandom_range(0, 9) == 0)
            d = $urandom_range(0, 65535);
        else
            d = int'(last_dist[ch]) + int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
        if (d < 0)
            d = 0;
        if (d > 65535)
            d = 65535;
        hit = ($urandom_range(0, 9) < 6);

        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_word(OP_CLR_ONE, ch, 1'($urandom), 1'($urandom),
                      DIST_W'($urandom), $urandom);
        end else if (r < 6) begin
            send_word(OP_CLR_ALL, CH_W'($urandom), 1'($urandom), 1'($urandom),
                      DIST_W'($urandom), $urandom);
        end else if (r < 8) begin
            send_word(OP_UNUSED, CH_W'($urandom), 1'($urandom), 1'($urandom),
                      DIST_W'($urandom), $urandom);
        end else if (r < 12) begin
            // non-collidable check drops the channel back to idle
            send_word(OP_CHECK, ch, 1'b0, hit, d[15:0], clock_ms);
        end else begin
            send_word(OP_CHECK, ch, 1'b1, hit, d[15:0], clock_ms);
            last_dist[ch] = d[15:0];
        end
    endtask

    initial begin : stimulus
        int phase_interval  [NUM_PHASES];
        int phase_threshold [NUM_PHASES];
        int p;
        int k;

        // every input known from the start
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CHECK;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IDX_INTERVAL;
        i_cfg_data    = '0;
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        clock_ms      = '0;
        for (k = 0; k < CH_SPAN; k++)
            last_dist[k] = '0;

        // register settings per phase, extremes first, defaults last
        phase_interval[0]  = 1;      phase_threshold[0] = 0;
        phase_interval[1]  = 65535;  phase_threshold[1] = 65535;
        phase_interval[2]  = $urandom_range(1, 4000);
        phase_threshold[2] = $urandom_range(0, 40);
        phase_interval[3]  = 1;      phase_threshold[3] = 65535;
        phase_interval[4]  = 65535;  phase_threshold[4] = 0;
        phase_interval[5]  = $urandom_range(1, 65535);
        phase_threshold[5] = $urandom_range(0, 65535);
        phase_interval[6]  = $urandom_range(1, 200);
        phase_threshold[6] = $urandom_range(0, 20);
        phase_interval[7]  = INTERVAL_RST;
        phase_threshold[7] = THRESHOLD_RST;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed opening at the reset settings (window 1000, threshold 5)
        send_word(OP_CHECK, 7'd0, 1'b1, 1'b0, 16'd100, 32'd0);
        send_word(OP_CHECK, 7'd0, 1'b1, 1'b1, 16'd102, 32'd500);
        // elapsed equal to the window does not close it
        send_word(OP_CHECK, 7'd0, 1'b1, 1'b0, 16'd103, 32'd1000);
        send_word(OP_CHECK, 7'd0, 1'b1, 1'b0, 16'd103, 32'd1001);
        // window closes across a timer wrap
        send_word(OP_CHECK, 7'd1, 1'b1, 1'b0, 16'd0, 32'hFFFF_FF00);
        send_word(OP_CHECK, 7'd1, 1'b1, 1'b1, 16'd4, 32'h0000_0400);
        // negative elapsed time, including the most negative value
        send_word(OP_CHECK, 7'd2, 1'b1, 1'b0, 16'hFFFF, 32'h7000_0000);
        send_word(OP_CHECK, 7'd2, 1'b1, 1'b1, 16'hFFFF, 32'h6000_0000);
        send_word(OP_CHECK, 7'd2, 1'b1, 1'b1, 16'hFFFF, 32'hF000_0000);
        // no collision rearms, move equal to the threshold rearms, then stuck
        send_word(OP_CHECK, 7'd3, 1'b1, 1'b0, 16'd10, 32'd0);
        send_word(OP_CHECK, 7'd3, 1'b1, 1'b0, 16'd10, 32'd2000);
        send_word(OP_CHECK, 7'd3, 1'b1, 1'b1, 16'd15, 32'd3001);
        send_word(OP_CHECK, 7'd3, 1'b1, 1'b1, 16'd14, 32'd4002);
        // full-scale move, non-collidable check, huge positive elapsed
        send_word(OP_CHECK, 7'd127, 1'b1, 1'b0, 16'hFFFF, 32'd5000);
        send_word(OP_CHECK, 7'd127, 1'b1, 1'b1, 16'd0, 32'd7000);
        send_word(OP_CHECK, 7'd127, 1'b0, 1'b1, 16'd0, 32'd7500);
        send_word(OP_CHECK, 7'd127, 1'b1, 1'b1, 16'd0, 32'd8000);
        send_word(OP_CHECK, 7'd127, 1'b1, 1'b1, 16'd1, 32'h7FFF_FFFF);
        // clear one channel, then clear all
        send_word(OP_CHECK, 7'd4, 1'b1, 1'b0, 16'd50, 32'd100);
        send_word(OP_CLR_ONE, 7'd4, 1'b0, 1'b0, 16'd0, 32'd0);
        send_word(OP_CHECK, 7'd4, 1'b1, 1'b1, 16'd50, 32'd5000);
        send_word(OP_CHECK, 7'd5, 1'b1, 1'b0, 16'd20, 32'd100);
        send_word(OP_CLR_ALL, 7'd0, 1'b0, 1'b0, 16'd0, 32'd0);
        send_word(OP_CHECK, 7'd5, 1'b1, 1'b1, 16'd20, 32'd9000);
        // unused operation with every field at its top
        send_word(OP_UNUSED, 7'h7F, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);

        for (p = 0; p < NUM_PHASES; p++) begin
            // registers change only with the block idle
            drain();
            write_reg(CFG_IDX_INTERVAL, CFG_W'(phase_interval[p]));
            write_reg(CFG_IDX_THRESHOLD, CFG_W'(phase_threshold[p]));
            send_gaps = (p != 4) && (p != NUM_PHASES - 1);
            recv_gaps = (p != NUM_PHASES - 1);
            if (p == 2)
                hold_req = 1'b1;
            for (k = 0; k < POOL_SIZE; k++)
                chan_pool[k] = CH_W'($urandom_range(0, CH_SPAN - 1));
            clock_ms = $urandom;
            for (k = 0; k < WORDS_PER_PHASE; k++)
                send_random_word(phase_interval[p], phase_threshold[p]);
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d words and %0d stuck verdicts", words_seen, stuck_seen);
        $display("over %0d register writes in %0d settings, incl. both extremes",
                 writes_seen, NUM_PHASES);
        if (fail_count == 0)
            $display("[progress_stall_watchdog_table_top] OK");
        else
            $display("[progress_stall_watchdog_table_top] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/pswd_pkg.sv
rtl/core/pswd_table.sv
rtl/core/pswd_eval.sv
rtl/core/progress_stall_watchdog_table_top.sv
sim/pswd_checker.sv
sim/tb.sv
